@@ rtl/lap7_pkg.sv @@
// Shared constants, types and register codes for the 7-point Laplacian stencil.
`timescale 1ns / 1ps
`default_nettype none
package lap7_pkg;

  localparam int MAX_X = 128;
  localparam int MAX_Y = 128;
  localparam int MAX_Z = 1024;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int RES_W    = 48;
  localparam int PX_W     = 7;
  localparam int PY_W     = 7;
  localparam int PZ_W     = 10;
  localparam int SXY_W    = 8;
  localparam int SZ_W     = 11;
  localparam int DIFF_W   = SAMPLE_W + 2;
  localparam int PROD_W   = DIFF_W + 17;
  localparam int SUM_W    = PROD_W + 2;
  localparam int ACC_W    = SUM_W + 1;
  localparam int WIN_DEPTH = 2 * MAX_X * MAX_Y;
  localparam int WIN_AW    = 1 + PY_W + PX_W;

  localparam logic signed [ACC_W-1:0] RES_HI = ACC_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] RES_LO = ACC_W'(48'sh8000_0000_0000);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

  typedef enum logic [2:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_INV_DX_SQ = 3'd3,
    REG_INV_DY_SQ = 3'd4,
    REG_INV_DZ_SQ = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SXY_W-1:0] sx;
    logic [SXY_W-1:0] sy;
    logic [SZ_W-1:0]  sz;
  } sizes_t;

  typedef struct packed {
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
    logic [PZ_W-1:0] z;
    logic            last;
  } cell_t;

  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage
`default_nettype wire

@@ rtl/lap7_ram.sv @@
// Generic single-write, dual-read RAM with registered, read-first outputs.
`timescale 1ns / 1ps
`default_nettype none
module lap7_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lap7_window.sv @@
// Raster position tracking, two-plane sample window and second differences.
`timescale 1ns / 1ps
`default_nettype none
module lap7_window import lap7_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire sizes_t              sizes,
  output logic                     d_valid,
  input  wire logic                d_ready,
  output diff_t                    dx,
  output diff_t                    dy,
  output diff_t                    dz,
  output cell_t                    d_cell
);

  logic [PX_W-1:0] pos_x;
  logic [PY_W-1:0] pos_y;
  logic [PZ_W-1:0] pos_z;
  logic [PZ_W-1:0] zc;
  logic            accept, x_end, y_end, z_end, emit, last;
  logic [WIN_AW-1:0] a_cur, a_ctr, a_xp, a_xm, a_yp, a_ym;
  logic [SAMPLE_W-1:0] xp_d, xm_d, yp_d, ym_d, zo_d, ce_d;

  logic                v1, emit1;
  cell_t               cell1;
  logic [SAMPLE_W-1:0] samp1;
  logic                v2;
  cell_t               cell2;
  diff_t               dx2, dy2, dz2;
  diff_t               c2;
  logic                r2;

  assign r2       = !v2 || d_ready;
  assign in_ready = !v1 || r2;
  assign accept   = in_valid && in_ready;

  always_comb begin
    x_end = ({1'b0, pos_x} + SXY_W'(1)) >= sizes.sx;
    y_end = ({1'b0, pos_y} + SXY_W'(1)) >= sizes.sy;
    z_end = ({1'b0, pos_z} + SZ_W'(1)) >= sizes.sz;
    zc    = pos_z - PZ_W'(1);
    emit  = (pos_x != '0) && (({1'b0, pos_x} + SXY_W'(2)) <= sizes.sx) &&
            (pos_y != '0) && (({1'b0, pos_y} + SXY_W'(2)) <= sizes.sy) &&
            (pos_z >= PZ_W'(2)) && (({1'b0, pos_z} + SZ_W'(1)) <= sizes.sz);
    last  = (({1'b0, pos_x} + SXY_W'(2)) == sizes.sx) &&
            (({1'b0, pos_y} + SXY_W'(2)) == sizes.sy) &&
            (({1'b0, zc} + SZ_W'(2)) == sizes.sz);
    a_cur = {pos_z[0], pos_y, pos_x};
    a_ctr = {~pos_z[0], pos_y, pos_x};
    a_xp  = {~pos_z[0], pos_y, pos_x + PX_W'(1)};
    a_xm  = {~pos_z[0], pos_y, pos_x - PX_W'(1)};
    a_yp  = {~pos_z[0], pos_y + PY_W'(1), pos_x};
    a_ym  = {~pos_z[0], pos_y - PY_W'(1), pos_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (x_end) begin
        pos_x <= '0;
        if (y_end) begin
          pos_y <= '0;
          pos_z <= z_end ? '0 : pos_z + PZ_W'(1);
        end else begin
          pos_y <= pos_y + PY_W'(1);
        end
      end else begin
        pos_x <= pos_x + PX_W'(1);
      end
    end
  end

  // three copies of the window, written alike, so six cells read at once
  lap7_ram #(.WIDTH(SAMPLE_W), .DEPTH(WIN_DEPTH)) u_ram_x (
    .clk(clk), .we(accept), .waddr(a_cur), .wdata(sample), .re(accept),
    .raddr_a(a_xp), .raddr_b(a_xm), .rdata_a(xp_d), .rdata_b(xm_d)
  );
  lap7_ram #(.WIDTH(SAMPLE_W), .DEPTH(WIN_DEPTH)) u_ram_y (
    .clk(clk), .we(accept), .waddr(a_cur), .wdata(sample), .re(accept),
    .raddr_a(a_yp), .raddr_b(a_ym), .rdata_a(yp_d), .rdata_b(ym_d)
  );
  // port a reads the minus-z cell before this item overwrites it
  lap7_ram #(.WIDTH(SAMPLE_W), .DEPTH(WIN_DEPTH)) u_ram_z (
    .clk(clk), .we(accept), .waddr(a_cur), .wdata(sample), .re(accept),
    .raddr_a(a_cur), .raddr_b(a_ctr), .rdata_a(zo_d), .rdata_b(ce_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      emit1 <= 1'b0;
    end else if (in_ready) begin
      v1    <= in_valid;
      emit1 <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell1 <= '{x: pos_x, y: pos_y, z: zc, last: last};
      samp1 <= sample;
    end
  end

  assign c2 = {{1{ce_d[SAMPLE_W-1]}}, ce_d, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      cell2 <= cell1;
      dx2 <= {{2{xp_d[SAMPLE_W-1]}}, xp_d} + {{2{xm_d[SAMPLE_W-1]}}, xm_d} - c2;
      dy2 <= {{2{yp_d[SAMPLE_W-1]}}, yp_d} + {{2{ym_d[SAMPLE_W-1]}}, ym_d} - c2;
      dz2 <= {{2{samp1[SAMPLE_W-1]}}, samp1} + {{2{zo_d[SAMPLE_W-1]}}, zo_d} - c2;
    end
  end

  assign d_valid = v2;
  assign d_cell  = cell2;
  assign dx      = dx2;
  assign dy      = dy2;
  assign dz      = dz2;

endmodule
`default_nettype wire

@@ rtl/lap7_arith.sv @@
// Scaling, summing, rounding and saturation pipeline for the stencil result.
`timescale 1ns / 1ps
`default_nettype none
module lap7_arith import lap7_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              d_valid,
  output logic                   d_ready,
  input  wire diff_t             dx,
  input  wire diff_t             dy,
  input  wire diff_t             dz,
  input  wire cell_t             cell_in,
  input  wire logic [COEF_W-1:0] inv_x,
  input  wire logic [COEF_W-1:0] inv_y,
  input  wire logic [COEF_W-1:0] inv_z,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [RES_W-1:0]       laplacian,
  output cell_t                  cell_out,
  output logic                   saturated
);

  logic v3, v4, v5, r3, r4, r5;
  cell_t cell3, cell4, cell5;
  logic signed [PROD_W-1:0] hx, hy, hz, lx, ly, lz;
  logic signed [SUM_W-1:0]  s_hi, s_lo, t;
  logic signed [ACC_W-1:0]  r;
  logic [RES_W-1:0]         lap5;
  logic                     sat5;

  assign r5      = !v5 || out_ready;
  assign r4      = !v4 || r5;
  assign r3      = !v3 || r4;
  assign d_ready = r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r3) v3 <= d_valid;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // split each coefficient into 16-bit halves to keep multipliers narrow
  always_ff @(posedge clk) begin
    if (r3 && d_valid) begin
      cell3 <= cell_in;
      hx <= dx * $signed({1'b0, inv_x[31:16]});
      hy <= dy * $signed({1'b0, inv_y[31:16]});
      hz <= dz * $signed({1'b0, inv_z[31:16]});
      lx <= dx * $signed({1'b0, inv_x[15:0]});
      ly <= dy * $signed({1'b0, inv_y[15:0]});
      lz <= dz * $signed({1'b0, inv_z[15:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      cell4 <= cell3;
      s_hi <= {{2{hx[PROD_W-1]}}, hx} + {{2{hy[PROD_W-1]}}, hy} + {{2{hz[PROD_W-1]}}, hz};
      s_lo <= {{2{lx[PROD_W-1]}}, lx} + {{2{ly[PROD_W-1]}}, ly} + {{2{lz[PROD_W-1]}}, lz};
    end
  end

  // round half up: floor((lo + 2^15) / 2^16)
  always_comb begin
    t = s_lo + ROUND_HALF;
    r = {s_hi[SUM_W-1], s_hi} + ACC_W'(t >>> 16);
  end

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      cell5 <= cell4;
      if (r > RES_HI) begin
        lap5 <= RES_HI[RES_W-1:0];
        sat5 <= 1'b1;
      end else if (r < RES_LO) begin
        lap5 <= RES_LO[RES_W-1:0];
        sat5 <= 1'b1;
      end else begin
        lap5 <= r[RES_W-1:0];
        sat5 <= 1'b0;
      end
    end
  end

  assign out_valid = v5;
  assign laplacian = lap5;
  assign cell_out  = cell5;
  assign saturated = sat5;

endmodule
`default_nettype wire

@@ rtl/laplacian_7point_3d_stencil.sv @@
// Top level of the streaming 7-point 3D Laplacian stencil.
//
// Input channel in_valid/in_ready/sample takes one signed Q16.16 sample per
// item in raster order (x fastest, then y, then z). Output channel
// out_valid/out_ready carries the Q32.16 laplacian of one interior cell with
// cell_x/cell_y/cell_z, saturated and last_cell. Boundary cells give no item.
// A cell's result is produced by the item that brings its plus-z neighbor.
// One item is taken per cycle unless the output stalls; the rate is set by
// the window RAM ports, read once per accepted item.
// Configuration is written through cfg_write/cfg_index/cfg_data, registers
// 0..5 being size_x, size_y, size_z, inv_dx_sq, inv_dy_sq, inv_dz_sq.
// Reset clears the raster position to (0,0,0), empties the pipeline and sets
// sizes to 128 and reciprocals to 1.0; the window contents are not cleared.
// When the receiver stalls, the pipeline fills and in_ready drops; nothing is
// lost or repeated, and the result on the output holds until taken.
`timescale 1ns / 1ps
`default_nettype none
module laplacian_7point_3d_stencil import lap7_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [RES_W-1:0]         laplacian,
  output logic [PX_W-1:0]          cell_x,
  output logic [PY_W-1:0]          cell_y,
  output logic [PZ_W-1:0]          cell_z,
  output logic                     saturated,
  output logic                     last_cell,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [COEF_W-1:0]   cfg_data
);

  logic [SXY_W-1:0]  size_x, size_y;
  logic [SZ_W-1:0]   size_z;
  logic [COEF_W-1:0] inv_dx_sq, inv_dy_sq, inv_dz_sq;
  sizes_t sizes;
  logic   d_valid, d_ready;
  diff_t  dx, dy, dz;
  cell_t  cell_d, cell_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SXY_W'(128);
      size_y    <= SXY_W'(128);
      size_z    <= SZ_W'(128);
      inv_dx_sq <= COEF_W'(65536);
      inv_dy_sq <= COEF_W'(65536);
      inv_dz_sq <= COEF_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SIZE_X:    size_x    <= cfg_data[SXY_W-1:0];
        REG_SIZE_Y:    size_y    <= cfg_data[SXY_W-1:0];
        REG_SIZE_Z:    size_z    <= cfg_data[SZ_W-1:0];
        REG_INV_DX_SQ: inv_dx_sq <= cfg_data;
        REG_INV_DY_SQ: inv_dy_sq <= cfg_data;
        REG_INV_DZ_SQ: inv_dz_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp each size to [1, max]
  always_comb begin
    sizes.sx = (size_x == '0) ? SXY_W'(1) : (size_x > SXY_W'(MAX_X)) ? SXY_W'(MAX_X) : size_x;
    sizes.sy = (size_y == '0) ? SXY_W'(1) : (size_y > SXY_W'(MAX_Y)) ? SXY_W'(MAX_Y) : size_y;
    sizes.sz = (size_z == '0) ? SZ_W'(1) : (size_z > SZ_W'(MAX_Z)) ? SZ_W'(MAX_Z) : size_z;
  end

  lap7_window u_window (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .sizes(sizes), .d_valid(d_valid), .d_ready(d_ready),
    .dx(dx), .dy(dy), .dz(dz), .d_cell(cell_d)
  );

  lap7_arith u_arith (
    .clk(clk), .rst(rst), .d_valid(d_valid), .d_ready(d_ready),
    .dx(dx), .dy(dy), .dz(dz), .cell_in(cell_d),
    .inv_x(inv_dx_sq), .inv_y(inv_dy_sq), .inv_z(inv_dz_sq),
    .out_valid(out_valid), .out_ready(out_ready), .laplacian(laplacian),
    .cell_out(cell_o), .saturated(saturated)
  );

  assign cell_x    = cell_o.x;
  assign cell_y    = cell_o.y;
  assign cell_z    = cell_o.z;
  assign last_cell = cell_o.last;

endmodule
`default_nettype wire

@@ rtl/lap7_checker.sv @@
// Port-level assertions for the stencil, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lap7_checker import lap7_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [RES_W-1:0] laplacian,
  input wire logic [PX_W-1:0]  cell_x,
  input wire logic [PY_W-1:0]  cell_y,
  input wire logic [PZ_W-1:0]  cell_z,
  input wire logic             saturated
);

  localparam logic [RES_W-1:0] SAT_POS = RES_HI[RES_W-1:0];
  localparam logic [RES_W-1:0] SAT_NEG = RES_LO[RES_W-1:0];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(laplacian))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> laplacian == SAT_POS || laplacian == SAT_NEG)
    else $error("saturated result not at a limit");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_x != '0 && cell_y != '0 && cell_z != '0)
    else $error("boundary cell emitted");

endmodule

bind laplacian_7point_3d_stencil lap7_checker u_lap7_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .laplacian(laplacian), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
  .saturated(saturated)
);
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the streaming 7-point 3D Laplacian stencil.
`timescale 1ns / 1ps
module tb;
  import lap7_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PIPE_SETTLE = 12;

  typedef struct {
    logic [RES_W-1:0] lap;
    logic [PX_W-1:0]  x;
    logic [PY_W-1:0]  y;
    logic [PZ_W-1:0]  z;
    logic             sat;
    logic             last;
  } cell_result_t;

  class laplacian_scoreboard;
    logic [SAMPLE_W-1:0] plane_store [WIN_DEPTH];
    int unsigned pos_x, pos_y, pos_z;
    logic [SZ_W-1:0] size_reg [3];
    logic [COEF_W-1:0] inv_sq [3];
    cell_result_t pending_cells [$];
    int unsigned n_sat, n_last;

    function new();
      pos_x = 0; pos_y = 0; pos_z = 0;
      size_reg[0] = 128; size_reg[1] = 128; size_reg[2] = 128;
      inv_sq[0] = 65536; inv_sq[1] = 65536; inv_sq[2] = 65536;
    endfunction

    function void set_reg(reg_idx_t idx, logic [COEF_W-1:0] value);
      case (idx)
        REG_SIZE_X: size_reg[0] = value[SXY_W-1:0];
        REG_SIZE_Y: size_reg[1] = value[SXY_W-1:0];
        REG_SIZE_Z: size_reg[2] = value[SZ_W-1:0];
        REG_INV_DX_SQ: inv_sq[0] = value;
        REG_INV_DY_SQ: inv_sq[1] = value;
        REG_INV_DZ_SQ: inv_sq[2] = value;
        default: ;
      endcase
    endfunction

    function int unsigned dim(int axis);
      int unsigned lim;
      lim = (axis == 0) ? MAX_X : (axis == 1) ? MAX_Y : MAX_Z;
      if (size_reg[axis] < 1) return 1;
      return (size_reg[axis] > lim) ? lim : size_reg[axis];
    endfunction

    function longint at(int unsigned x, int unsigned y, int unsigned z);
      logic [SAMPLE_W-1:0] w;
      w = plane_store[((z & 1) * MAX_Y + y) * MAX_X + x];
      return longint'(signed'(w));
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned sx, sy, sz, zc;
      longint c2, dx, dy, dz;
      logic signed [127:0] acc, dxw, dyw, dzw;
      cell_result_t res;
      sx = dim(0); sy = dim(1); sz = dim(2);
      if (pos_x >= 1 && pos_x + 2 <= sx && pos_y >= 1 && pos_y + 2 <= sy &&
          pos_z >= 2 && pos_z + 1 <= sz) begin
        zc = pos_z - 1;
        c2 = 2 * at(pos_x, pos_y, zc);
        dx = at(pos_x + 1, pos_y, zc) + at(pos_x - 1, pos_y, zc) - c2;
        dy = at(pos_x, pos_y + 1, zc) + at(pos_x, pos_y - 1, zc) - c2;
        dz = longint'(signed'(s)) + at(pos_x, pos_y, pos_z) - c2;
        dxw = dx; dyw = dy; dzw = dz;
        acc = dxw * $signed({96'b0, inv_sq[0]}) + dyw * $signed({96'b0, inv_sq[1]})
            + dzw * $signed({96'b0, inv_sq[2]});
        // round half up to Q32.16
        acc = (acc + 128'sd32768) >>> 16;
        res.sat = 1'b0;
        if (acc > 128'sh7FFF_FFFF_FFFF) begin
          acc = 128'sh7FFF_FFFF_FFFF; res.sat = 1'b1;
        end else if (acc < -128'sh8000_0000_0000) begin
          acc = -128'sh8000_0000_0000; res.sat = 1'b1;
        end
        res.lap = acc[RES_W-1:0];
        res.x = pos_x[PX_W-1:0];
        res.y = pos_y[PY_W-1:0];
        res.z = zc[PZ_W-1:0];
        res.last = (pos_x + 2 == sx && pos_y + 2 == sy && zc + 2 == sz);
        n_sat += res.sat;
        n_last += res.last;
        pending_cells.push_back(res);
      end
      plane_store[((pos_z & 1) * MAX_Y + pos_y) * MAX_X + pos_x] = s;
      if (pos_x + 1 >= sx) begin
        pos_x = 0;
        if (pos_y + 1 >= sy) begin
          pos_y = 0;
          pos_z = (pos_z + 1 >= sz) ? 0 : pos_z + 1;
        end else begin
          pos_y++;
        end
      end else begin
        pos_x++;
      end
    endfunction

    function string check_cell(cell_result_t got);
      cell_result_t want;
      if (pending_cells.size() == 0)
        return $sformatf("unexpected result at (%0d,%0d,%0d)", got.x, got.y, got.z);
      want = pending_cells.pop_front();
      if (got.lap !== want.lap || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.sat !== want.sat || got.last !== want.last)
        return $sformatf("cell (%0d,%0d,%0d) sat %0b last %0b lap %h, want (%0d,%0d,%0d) %0b %0b %h",
                         got.x, got.y, got.z, got.sat, got.last, got.lap,
                         want.x, want.y, want.z, want.sat, want.last, want.lap);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RES_W-1:0] laplacian;
  logic [PX_W-1:0] cell_x;
  logic [PY_W-1:0] cell_y;
  logic [PZ_W-1:0] cell_z;
  logic saturated, last_cell;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  laplacian_7point_3d_stencil u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .laplacian(laplacian), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .saturated(saturated), .last_cell(last_cell),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  laplacian_scoreboard sb = new();
  int unsigned n_errors, n_samples, n_cells, n_volumes, idle_cycles, out_stall;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic int pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side, stalls and watchdog
  always @(posedge clk) begin
    cell_result_t got;
    string msg;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.lap = laplacian; got.x = cell_x; got.y = cell_y; got.z = cell_z;
        got.sat = saturated; got.last = last_cell;
        msg = sb.check_cell(got);
        if (msg != "") report(msg);
        n_cells++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || cfg_write)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = pause_len();
      end
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    n_samples++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  // spike != 0 puts one extreme at the first interior cell, the opposite extreme elsewhere
  task automatic send_volume(int spike);
    int unsigned sx, sy, sz;
    logic [SAMPLE_W-1:0] s;
    sx = sb.dim(0); sy = sb.dim(1); sz = sb.dim(2);
    for (int unsigned z = 0; z < sz; z++)
      for (int unsigned y = 0; y < sy; y++)
        for (int unsigned x = 0; x < sx; x++) begin
          if (spike == 0) s = pick_sample();
          else if (x == 1 && y == 1 && z == 1) s = (spike > 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else s = (spike > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
          send_sample(s);
        end
    n_volumes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic reconfigure(logic [COEF_W-1:0] vals [6]);
    settle();
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(reg_idx_t'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic stream(int sx, int sy, int sz, logic [COEF_W-1:0] cx,
                        logic [COEF_W-1:0] cy, logic [COEF_W-1:0] cz,
                        int vols, int spike);
    logic [COEF_W-1:0] vals [6];
    vals = '{COEF_W'(sx), COEF_W'(sy), COEF_W'(sz), cx, cy, cz};
    reconfigure(vals);
    repeat (vols) send_volume(spike);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      3: return $urandom_range(1, 1 << 18);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: smallest volume, saturation both ways, zero reciprocal
    stream(3, 3, 3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
    stream(3, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    stream(3, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, -1);
    stream(3, 3, 3, 32'h0, 32'hFFFF_FFFF, 32'h0, 1, 1);
    // sizes too small for any interior cell, and a zero size
    stream(2, 5, 4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
    stream(5, 0, 3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
    stream(4, 4, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
    // random volumes, mostly small and well formed
    while (n_samples < 1400) begin
      if ($urandom_range(0, 9) == 0)
        stream($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
               pick_coef(), pick_coef(), pick_coef(), 1, 0);
      else
        stream($urandom_range(3, 7), $urandom_range(3, 6), $urandom_range(3, 6),
               pick_coef(), pick_coef(), pick_coef(), $urandom_range(1, 2), 0);
    end
    settle();
    $display("run: %0d samples in %0d volumes, %0d cells checked", n_samples, n_volumes, n_cells);
    $display("run: %0d saturated cells, %0d volume-end cells", sb.n_sat, sb.n_last);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
